// ===== rtl/r2n_pkg.sv =====
// Shared constants, types and a helper function of the RGB to NV12 converter.
package r2n_pkg;

	// Frame limits and derived widths
	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_HEIGHT  = 4096;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int SIZE_W      = 13;
	localparam int CMP_W       = SIZE_W + 1;
	localparam int STORE_DEPTH = MAX_WIDTH / 2;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int PAIR_W      = 9;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

	// Position of a pixel inside its 2x2 block and frame
	typedef struct packed {
		logic              odd_col;
		logic              odd_row;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} pos_t;

	// Effective frame size after clamping
	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} size_t;

	// Line store read request
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
	} lookup_t;

	// Per-pixel color terms
	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
	} color_t;

	// A size of zero acts as two, anything above the limit acts as the limit.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
	                                               input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_W'(2);
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

endpackage

// ===== rtl/r2n_if.sv =====
// Stream interfaces for RGB pixel items and YCbCr result items.
interface r2n_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface r2n_yuv_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma;
	logic       chroma_valid;
	logic [7:0] cb_avg;
	logic [7:0] cr_avg;
	logic       frame_last;

	modport source (output valid, output luma, output chroma_valid, output cb_avg,
		output cr_avg, output frame_last, input ready);
	modport sink (input valid, input luma, input chroma_valid, input cb_avg,
		input cr_avg, input frame_last, output ready);
endinterface

// ===== rtl/r2n_apb_regs.sv =====
// APB register file holding the frame width and height.
module r2n_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [r2n_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [r2n_pkg::APB_DATA_W-1:0] pwdata,
	output logic [r2n_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output r2n_pkg::size_t                 size
);
	import r2n_pkg::*;

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              wr_en;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes; bit zero is always cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_FRAME_WIDTH:  width_q  <= {pwdata[SIZE_W-1:1], 1'b0};
				REG_FRAME_HEIGHT: height_q <= {pwdata[SIZE_W-1:1], 1'b0};
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		case (reg_sel)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	// Effective sizes used by the position counters.
	assign size.width  = eff_size(width_q, SIZE_W'(MAX_WIDTH));
	assign size.height = eff_size(height_q, SIZE_W'(MAX_HEIGHT));

endmodule

// ===== rtl/r2n_color_stage.sv =====
// Input register and color matrix stage producing luma and chroma terms.
module r2n_color_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	input  r2n_pkg::pos_t    pos_in,
	output logic             out_valid,
	input  logic             out_ready,
	output r2n_pkg::color_t  color_s2,
	output r2n_pkg::pos_t    pos_s2,
	output r2n_pkg::lookup_t lookup
);
	import r2n_pkg::*;

	logic       v_s1;
	logic       v_s2;
	logic [7:0] red_s1;
	logic [7:0] green_s1;
	logic [7:0] blue_s1;
	pos_t       pos_s1;
	logic       adv_s2;
	logic [15:0] y_sum;
	logic [16:0] cb_sum;
	logic [16:0] cr_sum;
	color_t     color_next;

	assign adv_s2    = v_s1 && (!v_s2 || out_ready);
	assign in_ready  = !v_s1 || adv_s2;
	assign out_valid = v_s2;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (!v_s2 || out_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			pos_s1   <= pos_in;
		end
	end

	// BT.601 matrix with constant products; the chroma offsets keep the sums
	// positive so the floor shift is a plain bit select.
	always_comb begin
		y_sum  = 16'(16'd66 * red_s1) + 16'(16'd129 * green_s1)
			+ 16'(16'd25 * blue_s1) + 16'd128;
		cb_sum = 17'(17'd112 * blue_s1) + 17'd32896
			- 17'(17'd38 * red_s1) - 17'(17'd74 * green_s1);
		cr_sum = 17'(17'd112 * red_s1) + 17'd32896
			- 17'(17'd94 * green_s1) - 17'(17'd18 * blue_s1);
		color_next.luma = y_sum[15:8] + 8'd16;
		color_next.cb   = cb_sum[15:8];
		color_next.cr   = cr_sum[15:8];
	end

	// Term register.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			color_s2 <= color_next;
			pos_s2   <= pos_s1;
		end
	end

	// The line store is read as the item moves into the term register.
	assign lookup.en   = adv_s2;
	assign lookup.slot = pos_s1.slot;

endmodule

// ===== rtl/r2n_chroma_stage.sv =====
// Chroma pair sums, even-row line store, block averages and output register.
module r2n_chroma_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  r2n_pkg::color_t  color_s2,
	input  r2n_pkg::pos_t    pos_s2,
	input  r2n_pkg::lookup_t lookup,
	r2n_yuv_if.source        yuv
);
	import r2n_pkg::*;

	logic [2*PAIR_W-1:0] store_mem [STORE_DEPTH];
	logic [2*PAIR_W-1:0] rd_q;
	logic [PAIR_W-1:0]   pair_cb_q;
	logic [PAIR_W-1:0]   pair_cr_q;
	logic                v_s3;
	logic                adv_s3;
	logic [PAIR_W-1:0]   scb;
	logic [PAIR_W-1:0]   scr;
	logic [PAIR_W:0]     tcb;
	logic [PAIR_W:0]     tcr;
	logic                blk_done;

	assign adv_s3    = in_valid && (!v_s3 || yuv.ready);
	assign in_ready  = !v_s3 || yuv.ready;
	assign yuv.valid = v_s3;

	// Sums of the horizontal pair and of the whole 2x2 block.
	always_comb begin
		scb      = pair_cb_q + PAIR_W'(color_s2.cb);
		scr      = pair_cr_q + PAIR_W'(color_s2.cr);
		tcb      = (PAIR_W+1)'(rd_q[PAIR_W-1:0]) + (PAIR_W+1)'(scb);
		tcr      = (PAIR_W+1)'(rd_q[2*PAIR_W-1:PAIR_W]) + (PAIR_W+1)'(scr);
		blk_done = pos_s2.odd_col && pos_s2.odd_row;
	end

	// Line store: written at the odd column of even rows, read one stage early.
	always_ff @(posedge clk) begin
		if (adv_s3 && pos_s2.odd_col && !pos_s2.odd_row) begin
			store_mem[pos_s2.slot] <= {scr, scb};
		end
		if (lookup.en) begin
			rd_q <= store_mem[lookup.slot];
		end
	end

	// Even-column terms wait for their partner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_cb_q <= '0;
			pair_cr_q <= '0;
		end else if (adv_s3 && !pos_s2.odd_col) begin
			pair_cb_q <= PAIR_W'(color_s2.cb);
			pair_cr_q <= PAIR_W'(color_s2.cr);
		end
	end

	// Output register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (!v_s3 || yuv.ready) begin
			v_s3 <= in_valid;
		end
	end

	// Output register; the block average of at most 960 over four fits a byte.
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			yuv.luma         <= color_s2.luma;
			yuv.chroma_valid <= blk_done;
			yuv.cb_avg       <= blk_done ? tcb[PAIR_W:2] : 8'd0;
			yuv.cr_avg       <= blk_done ? tcr[PAIR_W:2] : 8'd0;
			yuv.frame_last   <= pos_s2.last;
		end
	end

endmodule

// ===== rtl/rgb_to_nv12_converter.sv =====
// Top level of the RGB to BT.601 YCbCr 4:2:0 converter with NV12 chroma order.
//
//   Channel  Direction  Handshake        Contents
//   pix      in         valid / ready    red, green, blue
//   yuv      out        valid / ready    luma, chroma_valid, cb_avg, cr_avg, frame_last
//   APB      in         psel / penable   frame_width at 0x0, frame_height at 0x4
//
// One item is accepted per cycle unless a stalled output has filled the stages.
// The line store has one read port and one write port; every item reads it, even-row pair ends write it.
// Reset clears the position counters, the pair sums and all valid bits.
// A stalled output holds its result while empty stages still accept items.
module rgb_to_nv12_converter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [r2n_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [r2n_pkg::APB_DATA_W-1:0] pwdata,
	output logic [r2n_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	r2n_pixel_if.sink                      pix,
	r2n_yuv_if.source                      yuv
);
	import r2n_pkg::*;

	size_t             size;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              col_last;
	logic              row_last;
	logic              in_acc;
	pos_t              pos_in;
	logic              mid_valid;
	logic              mid_ready;
	color_t            color_s2;
	pos_t              pos_s2;
	lookup_t           lookup;

	r2n_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.size    (size)
	);

	// Row and frame ends from the current position.
	always_comb begin
		col_last      = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(size.width);
		row_last      = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(size.height);
		in_acc        = pix.valid && pix.ready;
		pos_in.odd_col = col_q[0];
		pos_in.odd_row = row_q[0];
		pos_in.slot    = col_q[COL_W-1:1];
		pos_in.last    = col_last && row_last;
	end

	// Position counters advance once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	r2n_color_stage u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.red       (pix.red),
		.green     (pix.green),
		.blue      (pix.blue),
		.pos_in    (pos_in),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.color_s2  (color_s2),
		.pos_s2    (pos_s2),
		.lookup    (lookup)
	);

	r2n_chroma_stage u_chroma (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_ready (mid_ready),
		.color_s2 (color_s2),
		.pos_s2   (pos_s2),
		.lookup   (lookup),
		.yuv      (yuv)
	);

	// The last pixel of a frame returns both counters to the origin.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pos_in.last |=> col_q == '0 && row_q == '0)
		else $error("counters not cleared after last pixel of frame");

	// Any other pixel leaves the position away from the origin.
	a_no_early_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !pos_in.last |=> col_q != '0 || row_q != '0)
		else $error("counters returned to origin before end of frame");

	// Results without a finished block carry zero chroma.
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		yuv.valid && !yuv.chroma_valid |-> yuv.cb_avg == 8'd0 && yuv.cr_avg == 8'd0)
		else $error("chroma fields set without a finished block");

endmodule

// ===== tb/r2n_checker.sv =====
// Checker that predicts and compares the converter's YCbCr result items.
`timescale 1ns / 100ps

module r2n_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [r2n_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [r2n_pkg::APB_DATA_W-1:0] pwdata,
	r2n_pixel_if                           pix,
	r2n_yuv_if                             yuv,
	input  logic                           wrap_up,
	output int                             fail_count
);
	import r2n_pkg::*;

	// One result item as the converter should deliver it.
	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] cb_avg;
		logic [7:0] cr_avg;
		logic       frame_last;
	} yuv_item_t;

	// Predicted converter state: registers, position, pair sums and the line of pair sums.
	logic [SIZE_W-1:0]   width_reg;
	logic [SIZE_W-1:0]   height_reg;
	logic [COL_W-1:0]    col_pos;
	logic [ROW_W-1:0]    row_pos;
	logic [PAIR_W-1:0]   even_cb;
	logic [PAIR_W-1:0]   even_cr;
	logic [2*PAIR_W-1:0] line_sums [STORE_DEPTH];
	yuv_item_t           pending_yuv [$];
	int                  results_seen;
	logic                leftover_checked;

	// A cleared size acts as two; a size past the limit acts as the limit.
	function automatic int active_dim(input logic [SIZE_W-1:0] code, input int limit);
		int d;
		d = int'(code) & ~1;
		if (d == 0) begin
			d = 2;
		end else if (d > limit) begin
			d = limit;
		end
		return d;
	endfunction

	function automatic logic [7:0] clamp_byte(input int v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("checker: %s", what);
		fail_count++;
	endtask

	task automatic compare_field(input string field, input int got_v, input int want_v);
		if (got_v != want_v) begin
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				results_seen, field, got_v, want_v));
		end
	endtask

	// Converts one pixel and advances the frame position.
	task automatic convert_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
	                             output yuv_item_t res);
		int                  ri, gi, bi, cb_term, cr_term, w, h;
		logic [PAIR_W-1:0]   sum_cb, sum_cr;
		logic [SLOT_W-1:0]   slot;
		logic [2*PAIR_W-1:0] above;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		w = active_dim(width_reg, MAX_WIDTH);
		h = active_dim(height_reg, MAX_HEIGHT);
		res = '0;
		res.luma = clamp_byte(((66 * ri + 129 * gi + 25 * bi + 128) >>> 8) + 16);
		// Offset of 128 for rounding plus 128 << 8 for the chroma bias, floor shift.
		cb_term = (-38 * ri - 74 * gi + 112 * bi + 32896) >>> 8;
		cr_term = (112 * ri - 94 * gi - 18 * bi + 32896) >>> 8;
		slot = col_pos[COL_W-1:1];

		// Even columns open a pair; odd columns close it and either store or average.
		if (!col_pos[0]) begin
			even_cb = PAIR_W'(cb_term);
			even_cr = PAIR_W'(cr_term);
		end else begin
			sum_cb = even_cb + PAIR_W'(cb_term);
			sum_cr = even_cr + PAIR_W'(cr_term);
			if (!row_pos[0]) begin
				line_sums[slot] = {sum_cr, sum_cb};
			end else begin
				above = line_sums[slot];
				res.chroma_valid = 1'b1;
				res.cb_avg = clamp_byte((int'(above[PAIR_W-1:0]) + int'(sum_cb)) / 4);
				res.cr_avg = clamp_byte((int'(above[2*PAIR_W-1:PAIR_W]) + int'(sum_cr)) / 4);
			end
		end

		// A position at or past the last column or row wraps around.
		if (int'(col_pos) + 1 >= w) begin
			col_pos = '0;
			if (int'(row_pos) + 1 >= h) begin
				row_pos = '0;
				res.frame_last = 1'b1;
			end else begin
				row_pos = row_pos + 1'b1;
			end
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	// Watch register writes, pixel items and result items at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		yuv_item_t want, got;
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col_pos = '0;
			row_pos = '0;
			even_cb = '0;
			even_cr = '0;
			leftover_checked = 1'b0;
			pending_yuv.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[APB_ADDR_W-1:2] == REG_FRAME_WIDTH) begin
					width_reg = pwdata[SIZE_W-1:0] & ~SIZE_W'(1);
				end else begin
					height_reg = pwdata[SIZE_W-1:0] & ~SIZE_W'(1);
				end
			end

			// Results are matched before this edge's pixel is predicted.
			if (yuv.valid && yuv.ready) begin
				got = {yuv.luma, yuv.chroma_valid, yuv.cb_avg, yuv.cr_avg, yuv.frame_last};
				if (pending_yuv.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = pending_yuv.pop_front();
					compare_field("luma", got.luma, want.luma);
					compare_field("chroma_valid", got.chroma_valid, want.chroma_valid);
					compare_field("cb_avg", got.cb_avg, want.cb_avg);
					compare_field("cr_avg", got.cr_avg, want.cr_avg);
					compare_field("frame_last", got.frame_last, want.frame_last);
				end
				results_seen++;
			end

			if (pix.valid && pix.ready) begin
				convert_pixel(pix.red, pix.green, pix.blue, want);
				pending_yuv.push_back(want);
			end

			// At the end of the run every expected item must have been delivered.
			if (wrap_up && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (pending_yuv.size() != 0) begin
					report_mismatch($sformatf("%0d expected results never arrived",
						pending_yuv.size()));
				end
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the RGB to NV12 converter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
	import r2n_pkg::*;

	typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

	localparam int RUN_LIMIT      = 400000;
	localparam int DIRECTED_COUNT = 25;
	localparam int PHASE_COUNT    = 14;
	localparam int PHASE_ITEMS    = 80;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  wrap_up;
	int                    send_idle_pct;
	int                    recv_stall_pct;
	int                    pixels_sent;
	int                    results_taken;
	int                    cycle_count;
	int                    fail_count;

	r2n_pixel_if pix ();
	r2n_yuv_if   yuv ();

	rgb_to_nv12_converter u_dut (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready,
		.pix (pix),
		.yuv (yuv)
	);

	r2n_checker u_checker (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.pready,
		.paddr,
		.pwdata,
		.pix        (pix),
		.yuv        (yuv),
		.wrap_up,
		.fail_count
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver stalls, result count and the run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		yuv.ready <= ($urandom_range(99) >= recv_stall_pct);
		if (yuv.valid && yuv.ready) begin
			results_taken <= results_taken + 1;
		end
		if (cycle_count == RUN_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
		IDLE_NONE: begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		IDLE_SOURCE: begin
			send_idle_pct = 50;
			recv_stall_pct = 0;
		end
		IDLE_SINK: begin
			send_idle_pct = 0;
			recv_stall_pct = 50;
		end
		default: begin
			send_idle_pct = 38;
			recv_stall_pct = 38;
		end
		endcase
	endtask

	task automatic write_reg(input logic index, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'({index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offers one pixel after a random gap and returns once it is taken.
	task automatic send_pixel(input logic [23:0] rgb);
		while ($urandom_range(99) < send_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		{pix.red, pix.green, pix.blue} <= rgb;
		do @(posedge clk); while (!pix.ready);
		pixels_sent++;
	endtask

	// Holds the sender until every pixel has produced its result.
	task automatic wait_for_results();
		pix.valid <= 1'b0;
		do @(posedge clk); while (results_taken != pixels_sent);
	endtask

	function automatic logic [7:0] rand_level();
		case ($urandom_range(9))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Register value for a frame size, using the encodings that map onto the same size.
	function automatic logic [APB_DATA_W-1:0] encode_size(input int dim);
		logic [APB_DATA_W-1:0] code;
		code = APB_DATA_W'(dim);
		case ($urandom_range(5))
		0: code = code + 1'b1;
		1: code = code | ($urandom & 32'hFFFF_E000);
		default: begin
		end
		endcase
		if (dim == 2 && $urandom_range(1) == 1) begin
			code = APB_DATA_W'($urandom_range(1));
		end
		if (dim == MAX_HEIGHT && $urandom_range(1) == 1) begin
			code = APB_DATA_W'(MAX_HEIGHT + 1 + 2 * $urandom_range(0, 2046));
		end
		return code;
	endfunction

	// Two 2x2 blocks of saturated blue and red, then black, white and other corners.
	function automatic logic [23:0] directed_pixel(input int i);
		case (i)
		0, 1, 17, 18: return 24'h0000FF;
		2, 3, 19, 20: return 24'hFF0000;
		4, 21:        return 24'h000000;
		5, 16, 22:    return 24'hFFFFFF;
		6, 23:        return 24'hFFFF00;
		7, 24:        return 24'h00FFFF;
		8:            return 24'h00FF00;
		9:            return 24'hFF00FF;
		10:           return 24'h808080;
		11:           return 24'h7F7F7F;
		12:           return 24'h010101;
		13:           return 24'hFEFEFE;
		14:           return 24'h80017F;
		default:      return 24'h5AA5C3;
		endcase
	endfunction

	initial begin
		int                    width;
		int                    height;
		int                    frame_pixels;
		int                    phase_sent;
		logic                  held;
		logic [APB_DATA_W-1:0] width_code;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix.valid <= 1'b0;
		pix.red <= '0;
		pix.green <= '0;
		pix.blue <= '0;
		wrap_up <= 1'b0;
		held = 1'b0;
		set_idling(IDLE_NONE);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset size, then size changes in the middle of a frame.
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			// An odd width is cleared to four while at column 16, so the next pixel ends the row.
			if (i == 16) begin
				wait_for_results();
				write_reg(REG_FRAME_WIDTH, 32'd5);
			end
			// A height of one clears to zero and acts as two: row two ends the frame.
			if (i == 21) begin
				wait_for_results();
				write_reg(REG_FRAME_HEIGHT, 32'd1);
			end
			send_pixel(directed_pixel(i));
		end

		// Random phases of whole frames; the last two start frames of the largest sizes.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_for_results();
			set_idling(idle_mode_t'(p % 4));
			if (p == PHASE_COUNT - 2) begin
				width = MAX_WIDTH;
				height = 2;
			end else if (p == PHASE_COUNT - 1) begin
				width = 2;
				height = MAX_HEIGHT;
			end else begin
				width = 2 * $urandom_range(1, 12);
				height = 2 * $urandom_range(1, 4);
			end
			// The oversize width code is forced once so that clamping is always seen.
			width_code = (p == PHASE_COUNT - 2) ? 32'h0000_1FFF : encode_size(width);
			write_reg(REG_FRAME_WIDTH, width_code);
			write_reg(REG_FRAME_HEIGHT, encode_size(height));
			// A frame of the largest size is far too long, so only its first items are sent.
			if (p >= PHASE_COUNT - 2) begin
				frame_pixels = PHASE_ITEMS;
			end else begin
				frame_pixels = width * height;
			end
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS) begin
				for (int i = 0; i < frame_pixels; i++) begin
					// Once, the sender pauses mid-frame until the pipeline is empty.
					if (p == 5 && !held && i == frame_pixels / 2) begin
						wait_for_results();
						held = 1'b1;
					end
					send_pixel({rand_level(), rand_level(), rand_level()});
				end
				phase_sent += frame_pixels;
			end
		end

		// Let the pipeline settle, then check for leftovers and give the verdict.
		wait_for_results();
		repeat (8) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/r2n_pkg.sv
rtl/r2n_if.sv
rtl/r2n_apb_regs.sv
rtl/r2n_color_stage.sv
rtl/r2n_chroma_stage.sv
rtl/rgb_to_nv12_converter.sv
tb/r2n_checker.sv
tb/tb.sv
